// ===== rtl/servo_face_tracking_step_defines.svh =====
// ----------------------------------------------------------------------------
// Servo face tracking step: assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SERVO_FACE_TRACKING_STEP_DEFINES_SVH
`define SERVO_FACE_TRACKING_STEP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SFTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SFTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfts_pkg.sv =====
// ----------------------------------------------------------------------------
// sfts_pkg
// Types and constants shared by the servo face tracking step block.
// ----------------------------------------------------------------------------
package sfts_pkg;

    localparam int COORD_WIDTH     = 12;
    localparam int ANGLE_WIDTH     = 8;
    localparam int SIZE_WIDTH      = COORD_WIDTH - 1;
    localparam int SCALE_WIDTH     = 10;
    localparam int STEP_WIDTH      = 7;
    localparam int DIV_BITS        = STEP_WIDTH;
    localparam int ERR_WIDTH       = COORD_WIDTH + 1;
    localparam int MAG_WIDTH       = COORD_WIDTH;
    localparam int PROD_WIDTH      = MAG_WIDTH + SCALE_WIDTH;
    localparam int LAST_STAGE      = 2 + DIV_BITS;
    localparam int NUM_STAGES      = LAST_STAGE + 1;
    localparam int NEXT_WIDTH      = ANGLE_WIDTH + 2;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = (SCALE_WIDTH > ANGLE_WIDTH) ? SCALE_WIDTH : ANGLE_WIDTH;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN        = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_STEP    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANGLE_FLOOR = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANGLE_CEIL  = 2'd3;

    localparam logic [SCALE_WIDTH-1:0] GAIN_RST        = SCALE_WIDTH'(20);
    localparam logic [STEP_WIDTH-1:0]  MAX_STEP_RST    = STEP_WIDTH'(5);
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_FLOOR_RST = ANGLE_WIDTH'(0);
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_CEIL_RST  = ANGLE_WIDTH'(180);

    typedef struct packed {
        logic                          face_found;
        logic signed [COORD_WIDTH-1:0] box_left;
        logic signed [COORD_WIDTH-1:0] box_top;
        logic [SIZE_WIDTH-1:0]         box_width;
        logic [SIZE_WIDTH-1:0]         box_height;
        logic [SIZE_WIDTH-1:0]         frame_width;
        logic [SIZE_WIDTH-1:0]         frame_height;
        logic [ANGLE_WIDTH-1:0]        current_pan_angle;
        logic [ANGLE_WIDTH-1:0]        current_tilt_angle;
    } item_t;

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] new_pan_angle;
        logic                   pan_move;
        logic [ANGLE_WIDTH-1:0] new_tilt_angle;
        logic                   tilt_move;
    } result_t;

    typedef struct packed {
        logic [SCALE_WIDTH-1:0] gain;
        logic [STEP_WIDTH-1:0]  max_step;
        logic [ANGLE_WIDTH-1:0] angle_floor;
        logic [ANGLE_WIDTH-1:0] angle_ceil;
    } cfg_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] angle;
        logic                   move;
    } lane_out_t;

endpackage

// ===== rtl/servo_face_tracking_step.sv =====
// ----------------------------------------------------------------------------
// servo_face_tracking_step
// Pan and tilt servo update from one face box: two axis lanes side by side,
// merged into one result register.
//
//   channel   valid         stall          payload
//   request   item_valid    item_stall     item   (item_t)
//   result    result_valid  result_stall   result (result_t)
//   config    cfg_en        -              cfg_index, cfg_data
//
// One request per cycle while item_stall is low; each request passes through
// one error stage, one multiply stage, one overflow stage, seven divide stages
// of one quotient bit each, then the result register.
// Empty stages fill while the result register is stalled.
// rst_n clears stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`include "servo_face_tracking_step_defines.svh"

module servo_face_tracking_step
    import sfts_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  item_t                      item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output result_t                    result,
    input  logic                       cfg_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_t                  cfg_reg;
    pipe_ctl_t             ctl;
    logic                  last_valid;
    logic                  out_ready;
    logic                  active;
    lane_out_t             pan_res;
    lane_out_t             tilt_res;
    logic                  result_valid_reg;
    result_t               result_reg;
    logic                  lim_ok;
    logic                  pan_chk;
    logic                  pan_ok;
    logic                  tilt_chk;
    logic                  tilt_ok;
    logic                  step_wr;
    logic [STEP_WIDTH-1:0] step_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain        <= GAIN_RST;
            cfg_reg.max_step    <= MAX_STEP_RST;
            cfg_reg.angle_floor <= ANGLE_FLOOR_RST;
            cfg_reg.angle_ceil  <= ANGLE_CEIL_RST;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                CFG_GAIN:        cfg_reg.gain        <= cfg_data[SCALE_WIDTH-1:0];
                CFG_MAX_STEP:    cfg_reg.max_step    <= cfg_data[STEP_WIDTH-1:0];
                CFG_ANGLE_FLOOR: cfg_reg.angle_floor <= cfg_data[ANGLE_WIDTH-1:0];
                CFG_ANGLE_CEIL:  cfg_reg.angle_ceil  <= cfg_data[ANGLE_WIDTH-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign out_ready = !result_valid_reg || !result_stall;
    assign active    = item.face_found && (item.frame_width != '0)
                       && (item.frame_height != '0);

    sfts_ctl u_ctl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .out_ready  (out_ready),
        .item_stall (item_stall),
        .ctl        (ctl),
        .last_valid (last_valid)
    );

    sfts_lane u_pan (
        .clk    (clk),
        .ctl    (ctl),
        .cfg    (cfg_reg),
        .active (active),
        .corner (item.box_left),
        .size   (item.box_width),
        .frame  (item.frame_width),
        .cur    (item.current_pan_angle),
        .res    (pan_res)
    );

    sfts_lane u_tilt (
        .clk    (clk),
        .ctl    (ctl),
        .cfg    (cfg_reg),
        .active (active),
        .corner (item.box_top),
        .size   (item.box_height),
        .frame  (item.frame_height),
        .cur    (item.current_tilt_angle),
        .res    (tilt_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            result_valid_reg <= last_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && last_valid)
        begin
            result_reg.new_pan_angle  <= pan_res.angle;
            result_reg.pan_move       <= pan_res.move;
            result_reg.new_tilt_angle <= tilt_res.angle;
            result_reg.tilt_move      <= tilt_res.move;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign lim_ok     = cfg_reg.angle_floor <= cfg_reg.angle_ceil;
    assign pan_chk    = result_valid_reg && result_reg.pan_move && lim_ok;
    assign pan_ok     = (result_reg.new_pan_angle >= cfg_reg.angle_floor)
                        && (result_reg.new_pan_angle <= cfg_reg.angle_ceil);
    assign tilt_chk   = result_valid_reg && result_reg.tilt_move && lim_ok;
    assign tilt_ok    = (result_reg.new_tilt_angle >= cfg_reg.angle_floor)
                        && (result_reg.new_tilt_angle <= cfg_reg.angle_ceil);
    assign step_wr    = cfg_en && (cfg_index == CFG_MAX_STEP);
    assign step_wdata = cfg_data[STEP_WIDTH-1:0];

    `SFTS_ASSERT_IMP(a_no_stall_when_empty, !result_valid_reg, !item_stall, "stall while empty")
    `SFTS_ASSERT_IMP(a_pan_in_limits, pan_chk, pan_ok, "pan angle outside limits")
    `SFTS_ASSERT_IMP(a_tilt_in_limits, tilt_chk, tilt_ok, "tilt angle outside limits")
    `SFTS_ASSERT_NXT(a_step_wr, step_wr, cfg_reg.max_step == $past(step_wdata), "max_step lost")

endmodule

// ===== rtl/sfts_ctl.sv =====
// ----------------------------------------------------------------------------
// sfts_ctl
// Stage valid bits and load enables; bubbles collapse under a stalled output.
// ----------------------------------------------------------------------------
module sfts_ctl
    import sfts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      out_ready,
    output logic      item_stall,
    output pipe_ctl_t ctl,
    output logic      last_valid
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   en;

    always_comb
    begin
        en[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        ctl.load[0]   = item_valid && en[0];
        valid_next[0] = en[0] ? item_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            ctl.load[k]   = valid_reg[k-1] && en[k];
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign item_stall = !en[0];
    assign last_valid = valid_reg[LAST_STAGE];

endmodule

// ===== rtl/sfts_lane.sv =====
// ----------------------------------------------------------------------------
// sfts_lane
// One axis: pixel error, gain multiply, restoring divide one quotient bit
// per stage, step clamp and angle clamp.
// ----------------------------------------------------------------------------
module sfts_lane
    import sfts_pkg::*;
(
    input  logic                          clk,
    input  pipe_ctl_t                     ctl,
    input  cfg_t                          cfg,
    input  logic                          active,
    input  logic signed [COORD_WIDTH-1:0] corner,
    input  logic [SIZE_WIDTH-1:0]         size,
    input  logic [SIZE_WIDTH-1:0]         frame,
    input  logic [ANGLE_WIDTH-1:0]        cur,
    output lane_out_t                     res
);

    logic signed [ERR_WIDTH-1:0] err_full;
    logic [ERR_WIDTH-1:0]        err_abs;
    logic                        err_neg;

    logic                   neg_reg   [0:LAST_STAGE];
    logic                   act_reg   [0:LAST_STAGE];
    logic [ANGLE_WIDTH-1:0] cur_reg   [0:LAST_STAGE];
    logic [SIZE_WIDTH-1:0]  frame_reg [0:LAST_STAGE-1];
    logic [MAG_WIDTH-1:0]   mag_reg;
    logic [PROD_WIDTH-1:0]  rem_reg   [1:LAST_STAGE-1];
    logic                   big_reg   [2:LAST_STAGE];
    logic [STEP_WIDTH-1:0]  quo_reg   [3:LAST_STAGE];

    assign err_full = ERR_WIDTH'(corner)
                    + $signed({3'b000, size[SIZE_WIDTH-1:1]})
                    - $signed({3'b000, frame[SIZE_WIDTH-1:1]});
    assign err_neg  = err_full[ERR_WIDTH-1];
    assign err_abs  = err_neg ? ERR_WIDTH'(-err_full) : err_full;

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            neg_reg[0]   <= err_neg;
            act_reg[0]   <= active;
            cur_reg[0]   <= cur;
            frame_reg[0] <= frame;
            mag_reg      <= err_abs[MAG_WIDTH-1:0];
        end
        for (int k = 1; k <= LAST_STAGE; k++)
        begin
            if (ctl.load[k])
            begin
                neg_reg[k] <= neg_reg[k-1];
                act_reg[k] <= act_reg[k-1];
                cur_reg[k] <= cur_reg[k-1];
            end
        end
        for (int k = 1; k < LAST_STAGE; k++)
        begin
            if (ctl.load[k])
            begin
                frame_reg[k] <= frame_reg[k-1];
            end
        end
        if (ctl.load[1])
        begin
            rem_reg[1] <= PROD_WIDTH'(mag_reg) * PROD_WIDTH'(cfg.gain);
        end
        if (ctl.load[2])
        begin
            rem_reg[2] <= rem_reg[1];
            big_reg[2] <= rem_reg[1] >= PROD_WIDTH'({frame_reg[1], DIV_BITS'(0)});
        end
        for (int k = 3; k <= LAST_STAGE; k++)
        begin
            if (ctl.load[k])
            begin
                big_reg[k] <= big_reg[k-1];
            end
        end
    end

    for (genvar k = 3; k <= LAST_STAGE; k++)
    begin : g_div
        logic [PROD_WIDTH-1:0] dvs;
        logic                  fits;
        logic [STEP_WIDTH-1:0] q_prev;
        logic [STEP_WIDTH-1:0] q_next;

        assign dvs  = PROD_WIDTH'(frame_reg[k-1]) << (LAST_STAGE - k);
        assign fits = rem_reg[k-1] >= dvs;

        if (k == 3)
        begin : g_first
            assign q_prev = '0;
        end
        else
        begin : g_rest
            assign q_prev = quo_reg[k-1];
        end

        always_comb
        begin
            q_next                 = q_prev;
            q_next[LAST_STAGE - k] = fits;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.load[k])
            begin
                quo_reg[k] <= q_next;
            end
        end

        if (k < LAST_STAGE)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (ctl.load[k])
                begin
                    rem_reg[k] <= fits ? rem_reg[k-1] - dvs : rem_reg[k-1];
                end
            end
        end
    end

    logic [STEP_WIDTH-1:0]        step;
    logic                         move;
    logic signed [NEXT_WIDTH-1:0] cur_s;
    logic signed [NEXT_WIDTH-1:0] step_s;
    logic signed [NEXT_WIDTH-1:0] sum;
    logic [ANGLE_WIDTH-1:0]       clamped;

    always_comb
    begin
        if (big_reg[LAST_STAGE] || (quo_reg[LAST_STAGE] > cfg.max_step))
        begin
            step = cfg.max_step;
        end
        else
        begin
            step = quo_reg[LAST_STAGE];
        end
        move   = act_reg[LAST_STAGE] && (step != '0);
        cur_s  = $signed(NEXT_WIDTH'(cur_reg[LAST_STAGE]));
        step_s = $signed(NEXT_WIDTH'(step));
        // negative error means a negative step: angle goes up
        sum    = neg_reg[LAST_STAGE] ? cur_s + step_s : cur_s - step_s;
        if (sum < $signed(NEXT_WIDTH'(cfg.angle_floor)))
        begin
            clamped = cfg.angle_floor;
        end
        else if (sum > $signed(NEXT_WIDTH'(cfg.angle_ceil)))
        begin
            clamped = cfg.angle_ceil;
        end
        else
        begin
            clamped = sum[ANGLE_WIDTH-1:0];
        end
        res.move  = move;
        res.angle = move ? clamped : cur_reg[LAST_STAGE];
    end

endmodule
